// ----- sv/pcf_pkg.sv -----
package pcf_pkg;

    // operation codes carried on s_tuser
    localparam logic [1:0] OP_SIG   = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DATA  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam int unsigned TYPE_W = 32;
    localparam int unsigned LEN_W  = 31;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 4;   // up to twelve bytes per item

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]        op;
        logic [TYPE_W-1:0] chunk_type;
        logic [LEN_W-1:0]  data_length;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } beat_t;

    // reflected CRC-32, one byte folded in
    function automatic logic [31:0] crc_fold(input logic [31:0] c_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // big-endian byte k of a word (k = 0 is the most significant)
    function automatic logic [7:0] be_byte(input logic [31:0] w,
                                           input logic [1:0]  k);
        logic [7:0] r;
        case (k)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sig_byte(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = 8'd137;
            3'd1:    r = 8'd80;
            3'd2:    r = 8'd78;
            3'd3:    r = 8'd71;
            3'd4:    r = 8'd13;
            3'd5:    r = 8'd10;
            3'd6:    r = 8'd26;
            default: r = 8'd10;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/png_chunk_framer_crc32_top.sv -----
// Channel | Dir | Beat contents
// s_      | in  | tuser: op[1:0]; tdata: chunk_type[31:0], data_length[62:32],
//         |     |        data_byte[70:63], zero pad [71]
// m_      | out | tdata: out_byte[7:0]; tlast: last byte caused by an input beat
//
// Bytes go out one per cycle unless m_ stalls; an input beat stays in the
// holding register until every byte it causes is out (1 for a data byte, 5 when
// it closes the chunk, 8 for signature or chunk start, 12 for a zero-length
// start). Beats causing nothing are dropped. Data bytes stream back to back.
// Reset: synchronous, active-low aresetn; CRC returns to all ones, no chunk open.
// A stall on m_ holds the output register and backs up into s_tready.
module png_chunk_framer_crc32_top
    import pcf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // op
    input  logic [71:0] s_tdata,   // chunk_type, data_length, data_byte, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast
);

    item_t in_item;
    beat_t beat;
    logic  beat_valid;
    logic  slot_free;

    // unpack the input beat; bit 71 is padding
    assign in_item.op          = s_tuser;
    assign in_item.chunk_type  = s_tdata[31:0];
    assign in_item.data_length = s_tdata[62:32];
    assign in_item.data_byte   = s_tdata[70:63];

    // holding register, chunk state, CRC and byte selection
    pcf_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .slot_free  (slot_free),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    // output register toward m_
    pcf_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_valid),
        .beat       (beat),
        .slot_free  (slot_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ----- sv/pcf_emitter.sv -----
module pcf_emitter
    import pcf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  slot_free,
    output logic  beat_valid,
    output beat_t beat
);

    logic              h_valid_reg, h_valid_next;
    item_t             h_item_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [31:0]       crc_reg, crc_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic              open_reg, open_next;

    logic [IDX_W-1:0]  n_bytes;
    logic [1:0]        idx_m1;
    logic              last_idx;
    logic              emit;
    logic              done;
    logic              load;
    logic [7:0]        out_b;
    logic [7:0]        type_b;

    assign idx_m1   = idx_reg[1:0] - 2'd1;
    assign last_idx = (idx_reg == n_bytes - IDX_W'(1));
    assign emit     = h_valid_reg && (n_bytes != '0) && slot_free;
    assign done     = h_valid_reg && ((n_bytes == '0) || (emit && last_idx));
    assign in_ready = !h_valid_reg || done;
    assign load     = in_valid && in_ready;
    assign type_b   = be_byte(h_item_reg.chunk_type, idx_reg[1:0]);

    // bytes caused by the held item, and the byte at the current index
    always_comb begin
        n_bytes = '0;
        out_b   = '0;
        unique case (h_item_reg.op)
            OP_SIG: begin
                n_bytes = IDX_W'(8);
                out_b   = sig_byte(idx_reg[2:0]);
            end
            OP_START: begin
                n_bytes = (h_item_reg.data_length == '0) ? IDX_W'(12) : IDX_W'(8);
                if (idx_reg < IDX_W'(4)) begin
                    out_b = be_byte({1'b0, h_item_reg.data_length}, idx_reg[1:0]);
                end else if (idx_reg < IDX_W'(8)) begin
                    out_b = type_b;
                end else begin
                    out_b = be_byte(~crc_reg, idx_reg[1:0]);
                end
            end
            OP_DATA: begin
                if (open_reg) begin
                    n_bytes = (left_reg <= LEN_W'(1)) ? IDX_W'(5) : IDX_W'(1);
                end
                if (idx_reg == '0) begin
                    out_b = h_item_reg.data_byte;
                end else begin
                    out_b = be_byte(~crc_reg, idx_m1);
                end
            end
            OP_NONE: begin
                n_bytes = '0;
            end
            default: begin
                n_bytes = '0;
            end
        endcase
    end

    assign beat_valid = emit;
    assign beat.data  = out_b;
    assign beat.last  = last_idx;

    always_comb begin
        h_valid_next = h_valid_reg;
        idx_next     = idx_reg;
        crc_next     = crc_reg;
        left_next    = left_reg;
        open_next    = open_reg;

        if (done) begin
            h_valid_next = 1'b0;
            idx_next     = '0;
        end else if (emit) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (load) begin
            h_valid_next = 1'b1;
        end

        if (emit && h_item_reg.op == OP_START) begin
            // CRC over the type bytes as they go out
            if (idx_reg == IDX_W'(4)) begin
                crc_next = crc_fold(CRC_INIT, type_b);
            end else if (idx_reg >= IDX_W'(5) && idx_reg <= IDX_W'(7)) begin
                crc_next = crc_fold(crc_reg, type_b);
            end
            if (last_idx) begin
                if (h_item_reg.data_length == '0) begin
                    crc_next  = CRC_INIT;
                    open_next = 1'b0;
                    left_next = '0;
                end else begin
                    open_next = 1'b1;
                    left_next = h_item_reg.data_length;
                end
            end
        end

        if (emit && h_item_reg.op == OP_DATA) begin
            if (idx_reg == '0) begin
                crc_next  = crc_fold(crc_reg, h_item_reg.data_byte);
                left_next = left_reg - LEN_W'(1);
            end else if (last_idx) begin
                crc_next  = CRC_INIT;
                open_next = 1'b0;
                left_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
            idx_reg     <= '0;
            crc_reg     <= CRC_INIT;
            left_reg    <= '0;
            open_reg    <= 1'b0;
        end else begin
            h_valid_reg <= h_valid_next;
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            left_reg    <= left_next;
            open_reg    <= open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            h_item_reg <= in_item;
        end
    end

`ifndef SYNTHESIS
    a_closed_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !open_reg |-> left_reg == '0)
        else $error("bytes_left nonzero with no open chunk");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg < IDX_W'(12))
        else $error("byte index out of range");

    a_zero_left_closing: assert property (@(posedge aclk) disable iff (!aresetn)
        (open_reg && left_reg == '0) |->
            (h_valid_reg && h_item_reg.op == OP_DATA && idx_reg != '0))
        else $error("open chunk with no bytes left outside CRC trailer");

    a_idx_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> idx_reg == '0)
        else $error("index not cleared after item");
`endif

endmodule

// ----- sv/pcf_out_reg.sv -----
module pcf_out_reg
    import pcf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       beat_valid,
    input  beat_t      beat,
    output logic       slot_free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic  valid_reg, valid_next;
    beat_t beat_reg;

    assign slot_free  = !valid_reg || m_tready;
    assign valid_next = slot_free ? beat_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && beat_valid) begin
            beat_reg <= beat;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = beat_reg.data;
    assign m_tlast  = beat_reg.last;

`ifndef SYNTHESIS
    a_take_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_free && beat_valid) |=> m_tvalid)
        else $error("offered beat not registered");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !beat_valid) |=> !m_tvalid)
        else $error("output valid without a new beat");

    a_no_take_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !slot_free)
        else $error("slot reported free while stalled");
`endif

endmodule

// ----- dv/png_chunk_framer_crc32_top_test.sv -----
module png_chunk_framer_crc32_top_test;
    import pcf_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int TAIL_CYCLES  = 20;      // well past the 12-byte worst case
    localparam int RANDOM_ITEMS = 370;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser  = OP_NONE;     // op
    logic [71:0] s_tdata  = '0;          // chunk_type, data_length, data_byte, pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;                // out_byte
    logic        m_tlast;

    // framer model state
    logic [31:0] model_crc  = CRC_INIT;
    logic [30:0] model_left = '0;
    logic        model_open = 1'b0;

    beat_t stream_q[$];                  // stream bytes still owed by the block
    int    err_count   = 0;
    int    beat_count  = 0;
    int    cycle_count = 0;
    int    burst_left  = 0;
    int    busy_items  = 0;              // accepted items that caused output

    png_chunk_framer_crc32_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Framer model
    // ------------------------------------------------------------------

    // reflected CRC-32 step, one bit per pass
    function automatic logic [31:0] crc_byte_step(input logic [31:0] c,
                                                  input logic [7:0]  d);
        logic [31:0] r;
        r = c ^ {24'd0, d};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction

    // works out the stream bytes one accepted beat owes; returns their count
    function automatic int frame_bytes(input item_t it);
        logic [7:0]  ob[12];
        logic [7:0]  sig[8];
        logic [31:0] len_word;
        logic [31:0] crc_out;
        int          n;
        beat_t       bt;
        sig = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
        n   = 0;
        case (it.op)
            OP_SIG: begin
                for (int i = 0; i < 8; i++) begin
                    ob[n] = sig[i];
                    n     = n + 1;
                end
            end
            OP_START: begin
                len_word = {1'b0, it.data_length};
                for (int i = 3; i >= 0; i--) begin
                    ob[n] = len_word[8*i +: 8];
                    n     = n + 1;
                end
                model_crc = CRC_INIT;
                for (int i = 3; i >= 0; i--) begin
                    ob[n]     = it.chunk_type[8*i +: 8];
                    n         = n + 1;
                    model_crc = crc_byte_step(model_crc, it.chunk_type[8*i +: 8]);
                end
                model_left = it.data_length;
                model_open = 1'b1;
            end
            OP_DATA: begin
                if (model_open) begin
                    ob[n]      = it.data_byte;
                    n          = n + 1;
                    model_crc  = crc_byte_step(model_crc, it.data_byte);
                    model_left = model_left - 31'd1;
                end
            end
            default: ;
        endcase
        // chunk complete: inverted CRC, big-endian
        if (n > 0 && it.op != OP_SIG && model_left == '0) begin
            crc_out = model_crc ^ CRC_INIT;
            for (int i = 3; i >= 0; i--) begin
                ob[n] = crc_out[8*i +: 8];
                n     = n + 1;
            end
            model_crc  = CRC_INIT;
            model_open = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            bt.data = ob[i];
            bt.last = (i == n - 1);
            stream_q.push_back(bt);
        end
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [1:0]  op,
                             input logic [31:0] ctype,
                             input logic [30:0] len,
                             input logic [7:0]  db);
        item_t it;
        int    gap;
        it.op          = op;
        it.chunk_type  = ctype;
        it.data_length = len;
        it.data_byte   = db;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, db, len, ctype};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (frame_bytes(it) > 0) begin
            busy_items++;
        end
    endtask

    // hold off the sender until the block has emitted everything owed
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (stream_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern switching between free-run, coin flip, long runs
    // ------------------------------------------------------------------
    int   rx_mode   = 0;
    int   mode_left = 0;
    int   run_left  = 0;
    logic run_level = 1'b1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if (run_left == 0) begin
                        run_level = !run_level;
                        run_left  = run_level ? $urandom_range(1, 12)
                                              : $urandom_range(1, 8);
                    end else begin
                        run_left--;
                    end
                    m_tready <= run_level;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what,
                                   input logic [7:0] got,
                                   input logic [7:0] want);
        if (err_count < PRINT_CAP) begin
            $display("mismatch on %s at beat %0d: got %02h expected %02h",
                     what, beat_count, got, want);
        end
        err_count++;
    endtask

    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (stream_q.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, 8'h00);
            end else begin
                want = stream_q.pop_front();
                if (m_tdata !== want.data) begin
                    report_mismatch("out_byte", m_tdata, want.data);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last", {7'd0, m_tlast}, {7'd0, want.last});
                end
            end
            beat_count++;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    task automatic test_signature();
        send_beat(OP_SIG, 32'h0, 31'h0, 8'h0);
    endtask

    // IEND has a well-known CRC; an all-ones type covers the top of the range
    task automatic test_zero_length();
        send_beat(OP_START, 32'h4945_4E44, 31'd0, 8'h00);
        send_beat(OP_START, 32'hFFFF_FFFF, 31'd0, 8'hFF);
    endtask

    task automatic test_short_chunk();
        send_beat(OP_START, 32'h4944_4154, 31'd2, 8'h00);
        send_beat(OP_DATA, 32'h0, 31'h0, 8'h00);
        send_beat(OP_DATA, 32'h0, 31'h0, 8'hFF);
    endtask

    // data with no chunk open and the spare op code: both silent
    task automatic test_stray_items();
        send_beat(OP_DATA, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF);
        send_beat(OP_NONE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF);
    endtask

    // signature mid-chunk leaves it open; a new start abandons it
    task automatic test_nesting();
        send_beat(OP_START, 32'h0000_0000, 31'd3, 8'h00);
        send_beat(OP_DATA, 32'h0, 31'h0, 8'h5A);
        send_beat(OP_SIG, 32'h0, 31'h0, 8'h0);
        send_beat(OP_DATA, 32'h0, 31'h0, 8'hC3);
        send_beat(OP_START, 32'h7445_5874, 31'd1, 8'h00);
        send_beat(OP_DATA, 32'h0, 31'h0, 8'h81);
    endtask

    task automatic test_field_extremes();
        send_beat(OP_START, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'h00);
        send_beat(OP_DATA, 32'h0, 31'h0, 8'hFF);
        send_beat(OP_DATA, 32'h0, 31'h0, 8'h00);
        send_beat(OP_START, 32'h8000_0001, 31'h4000_0000, 8'h00);
        send_beat(OP_START, 32'h0000_0000, 31'd1, 8'h00);
        send_beat(OP_DATA, 32'h0, 31'h0, 8'hA5);
    endtask

    // ------------------------------------------------------------------
    // Random frames: mostly complete chunks, some noise and broken chunks
    // ------------------------------------------------------------------
    task automatic test_random_frames();
        int          pick;
        int          len;
        int          cut;
        bit          paused;
        logic [31:0] ctype;
        paused     = 1'b0;
        busy_items = 0;
        while (busy_items < RANDOM_ITEMS) begin
            if (!paused && busy_items >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            pick  = $urandom_range(0, 99);
            ctype = $urandom();
            if (pick < 68) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                send_beat(OP_START, ctype, len[30:0], 8'($urandom()));
                for (int k = 0; k < len; k++) begin
                    send_beat(OP_DATA, $urandom(), 31'($urandom()), 8'($urandom()));
                end
            end else if (pick < 76) begin
                send_beat(OP_SIG, $urandom(), 31'($urandom()), 8'($urandom()));
            end else if (pick < 84) begin
                // noise: spare op or a data byte that may land outside a chunk
                send_beat($urandom_range(0, 1) ? OP_NONE : OP_DATA,
                          $urandom(), 31'($urandom()), 8'($urandom()));
            end else if (pick < 93) begin
                // broken chunk, often with a huge length; left for the next start
                len = ($urandom_range(0, 1) == 0) ? ($urandom() & 32'h7FFF_FFFF)
                                                  : $urandom_range(2, 12);
                cut = $urandom_range(0, 5);
                if (len <= cut) begin
                    cut = len - 1;
                end
                send_beat(OP_START, ctype, len[30:0], 8'($urandom()));
                for (int k = 0; k < cut; k++) begin
                    send_beat(OP_DATA, $urandom(), 31'($urandom()), 8'($urandom()));
                end
            end else begin
                // signature dropped into the middle of a chunk
                len = $urandom_range(2, 10);
                cut = $urandom_range(1, len - 1);
                send_beat(OP_START, ctype, len[30:0], 8'($urandom()));
                for (int k = 0; k < len; k++) begin
                    if (k == cut) begin
                        send_beat(OP_SIG, $urandom(), 31'($urandom()), 8'($urandom()));
                    end
                    send_beat(OP_DATA, $urandom(), 31'($urandom()), 8'($urandom()));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_signature();
        test_zero_length();
        test_short_chunk();
        wait_drained();
        test_stray_items();
        test_nesting();
        test_field_extremes();
        wait_drained();
        test_random_frames();
        wait_drained();

        if (err_count == 0 && stream_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- png_chunk_framer_crc32_top.f -----
sv/pcf_pkg.sv
sv/pcf_emitter.sv
sv/pcf_out_reg.sv
sv/png_chunk_framer_crc32_top.sv
dv/png_chunk_framer_crc32_top_test.sv
